[rtl/core/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants
// Sizes, status codes and the table-entry type of the heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int HEAP_BYTES_DEF   = 65536;
  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 16;

  localparam logic [16:0] LIMIT_RESET = 17'd65536;
  localparam int          SIZE_STEP   = 8;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NULL    = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic [24:0] start;
    logic [24:0] size;
    logic        free;
  } entry_t;

endpackage

[rtl/core/first_fit_heap_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit heap allocator
// Address-ordered block table with split on allocate and merge on release.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries opcode, request_size and
//   release_address; the output channel out_valid/out_stall carries address
//   and status, exactly one result item per input item. The user must write
//   heap_limit by cfg_we/cfg_data only while idle; the block does not check.
// Operation:
//   The sequencer drives one table memory with one registered read port and
//   one write port. An item scans the entries one by one (read state S_RD,
//   check state S_CHK) up to the hit or the table end, then shifts entries
//   one by one (S_SHRD, S_SHWR) for an insert (split) or a removal (merge).
//   Scan and shift together cover at most the table. in_stall stays high
//   until the result has been taken; one item is in work at a time.
// Reset:
//   rst clears the entry count and heap top and loads heap_limit with 65536.
//   The table itself is not cleared; only entries below the count are read.
// Stall:
//   While out_stall is high the result item holds on the output.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [15:0] request_size,
  input  logic [15:0] release_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] address,
  output logic [1:0]  status
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD    = 9'b000000010,
    S_CHK   = 9'b000000100,
    S_GROW  = 9'b000001000,
    S_SHRD  = 9'b000010000,
    S_SHWR  = 9'b000100000,
    S_NXRD  = 9'b001000000,
    S_NXCHK = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;

  logic [16:0]     heap_limit;
  logic [24:0]     heap_top;
  logic [CW-1:0]   count;
  logic            op;
  logic [24:0]     want;       // rounded size
  logic [15:0]     rel_addr;
  logic [CW-1:0]   idx;        // scan index
  logic [CW-1:0]   sh;         // shift index
  logic            shift_up;   // insert (up) or remove (down)
  logic [CW-1:0]   sh_end;
  ffha_pkg::entry_t hold;      // entry read at the check (hit or released entry)
  ffha_pkg::entry_t ins;       // entry inserted at sh_end after shift up

  logic             we;
  logic [IW-1:0]    waddr, raddr;
  ffha_pkg::entry_t wdata, rdata;

  ffha_table #(.MAX_BLOCKS(MAX_BLOCKS), .IW(IW)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [24:0] limit_eff;
  logic [24:0] req_round;
  logic [25:0] grow_end;
  logic        full;
  assign limit_eff = ({8'd0, heap_limit} > 25'(HEAP_BYTES)) ? 25'(HEAP_BYTES)
                                                          : {8'd0, heap_limit};
  assign req_round = 25'(({1'b0, request_size} + 17'd7) & ~17'd7);
  assign grow_end  = {1'b0, heap_top} + {1'b0, want} + 26'(HEADER_BYTES);
  assign full      = (count == CW'(MAX_BLOCKS));

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    raddr = idx[IW-1:0];
    if (state == S_SHRD) begin
      raddr = shift_up ? IW'(sh - 1'b1) : IW'(sh + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      heap_limit <= ffha_pkg::LIMIT_RESET;
      heap_top   <= '0;
      count      <= '0;
      we         <= 1'b0;
    end else begin
      if (cfg_we) begin
        heap_limit <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          we <= 1'b0;
          if (in_valid) begin
            op       <= opcode;
            want     <= req_round;
            rel_addr <= release_address;
            idx      <= '0;
            address  <= '0;
            if (opcode == ffha_pkg::OP_ALLOC && request_size == 16'd0) begin
              status <= ffha_pkg::ST_NULL;
              state  <= S_OUT;
            end else if (opcode == ffha_pkg::OP_RELEASE && release_address == 16'd0) begin
              status <= ffha_pkg::ST_DONE;
              state  <= S_OUT;
            end else if (count == '0) begin
              state  <= (opcode == ffha_pkg::OP_ALLOC) ? S_GROW : S_OUT;
              status <= (opcode == ffha_pkg::OP_RELEASE) ? ffha_pkg::ST_UNKNOWN
                                                         : ffha_pkg::ST_DONE;
            end else begin
              status <= ffha_pkg::ST_DONE;
              state  <= S_RD;
            end
          end
        end
        S_RD: begin
          we    <= 1'b0;
          state <= S_CHK;
        end
        S_CHK: begin
          hold <= rdata;
          if (op == ffha_pkg::OP_ALLOC) begin
            if (rdata.free && rdata.size >= want) begin
              address <= 16'(rdata.start + 25'(HEADER_BYTES));
              if ({1'b0, rdata.size} >= {1'b0, want} + 26'(HEADER_BYTES + ffha_pkg::SIZE_STEP)
                  && !full) begin
                // split: shrink hit, insert free rest after it
                we    <= 1'b1;
                waddr <= idx[IW-1:0];
                wdata <= '{start: rdata.start, size: want, free: 1'b0};
                ins   <= '{start: rdata.start + 25'(HEADER_BYTES) + want,
                           size: rdata.size - want - 25'(HEADER_BYTES), free: 1'b1};
                sh_end   <= idx + 1'b1;
                sh       <= count;
                shift_up <= 1'b1;
                count    <= count + 1'b1;
                state    <= (count == idx + 1'b1) ? S_SHWR : S_SHRD;
              end else begin
                we    <= 1'b1;
                waddr <= idx[IW-1:0];
                wdata <= '{start: rdata.start, size: rdata.size, free: 1'b0};
                state <= S_OUT;
              end
            end else if (idx + 1'b1 == count) begin
              we    <= 1'b0;
              state <= S_GROW;
            end else begin
              we    <= 1'b0;
              idx   <= idx + 1'b1;
              state <= S_RD;
            end
          end else begin
            if (rdata.start + 25'(HEADER_BYTES) == {9'd0, rel_addr}) begin
              we    <= 1'b1;
              waddr <= idx[IW-1:0];
              wdata <= '{start: rdata.start, size: rdata.size, free: 1'b1};
              if (idx + 1'b1 == count) begin
                state <= S_OUT;
              end else begin
                idx   <= idx + 1'b1;
                state <= S_NXRD;
              end
            end else if (idx + 1'b1 == count) begin
              we     <= 1'b0;
              status <= ffha_pkg::ST_UNKNOWN;
              state  <= S_OUT;
            end else begin
              we    <= 1'b0;
              idx   <= idx + 1'b1;
              state <= S_RD;
            end
          end
        end
        S_GROW: begin
          if (full || grow_end > {1'b0, limit_eff}) begin
            we     <= 1'b0;
            status <= ffha_pkg::ST_NOSPACE;
          end else begin
            we       <= 1'b1;
            waddr    <= count[IW-1:0];
            wdata    <= '{start: heap_top, size: want, free: 1'b0};
            address  <= 16'(heap_top + 25'(HEADER_BYTES));
            heap_top <= grow_end[24:0];
            count    <= count + 1'b1;
          end
          state <= S_OUT;
        end
        S_NXRD: begin
          we    <= 1'b0;
          state <= S_NXCHK;
        end
        S_NXCHK: begin
          // hold is the released entry, rdata its follower
          if (rdata.free && hold.start + 25'(HEADER_BYTES) + hold.size == rdata.start) begin
            we    <= 1'b1;
            waddr <= IW'(idx - 1'b1);
            wdata <= '{start: hold.start,
                       size: hold.size + 25'(HEADER_BYTES) + rdata.size, free: 1'b1};
            shift_up <= 1'b0;
            sh       <= idx;
            count    <= count - 1'b1;
            state    <= (idx + 1'b1 == count) ? S_OUT : S_SHRD;
          end else begin
            we    <= 1'b0;
            state <= S_OUT;
          end
        end
        S_SHRD: begin
          we    <= 1'b0;
          state <= S_SHWR;
        end
        S_SHWR: begin
          we <= 1'b1;
          if (shift_up) begin
            waddr <= sh[IW-1:0];
            if (sh == sh_end) begin
              wdata <= ins;
              state <= S_OUT;
            end else begin
              wdata <= rdata;
              sh    <= sh - 1'b1;
              state <= (sh - 1'b1 == sh_end) ? S_SHWR : S_SHRD;
            end
          end else begin
            // remove: entry sh takes sh+1; count already lowered
            waddr <= sh[IW-1:0];
            wdata <= rdata;
            sh    <= sh + 1'b1;
            state <= (sh + 1'b1 == count) ? S_OUT : S_SHRD;
          end
        end
        S_OUT: begin
          we <= 1'b0;
          if (!out_stall) state <= S_IDLE;
        end
        default: begin
          we    <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/ffha_table.sv]
// ----------------------------------------------------------------------------
// ffha_table: block table memory
// One write port and one registered read port over the entry array.
// ----------------------------------------------------------------------------
module ffha_table #(
  parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int IW         = $clog2(MAX_BLOCKS)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IW-1:0]     waddr,
  input  ffha_pkg::entry_t  wdata,
  input  logic [IW-1:0]     raddr,
  output ffha_pkg::entry_t  rdata
);

  ffha_pkg::entry_t mem [MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
